@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the UART block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside of reset.
`define HDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside of reset.
`define HDU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/hdu_pkg.sv @@
// ---------------------------------------------------------------------------
// hdu_pkg
// Types, codes and constants shared by the half-duplex UART and its FIFOs.
// ---------------------------------------------------------------------------
package hdu_pkg;

  localparam int RX_DEPTH_DFLT = 16;
  localparam int TX_DEPTH_DFLT = 16;

  localparam int TIMER_W = 9;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [TIMER_W-1:0] BIT_PERIOD_RST = 9'd104;
  localparam logic [TIMER_W-1:0] START_DELAY_RST = 9'd154;
  // 256 ticks of turnaround wait by default; the 9-bit register holds up to 511.
  localparam logic [TIMER_W-1:0] TURNAROUND_RST = 9'd256;

  localparam logic [3:0] RX_DATA_BITS = 4'd8;
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [9:0] SHIFT_IDLE = 10'h3FF;
  localparam logic [9:0] SHIFT_RX_START = 10'h0FF;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_POP   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_RX   = 3'd1,
    MODE_WAIT = 3'd2,
    MODE_TX   = 3'd3,
    MODE_PRE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD  = 2'd0,
    REG_START_DELAY = 2'd1,
    REG_TURNAROUND  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       rx_line;
    logic [7:0] tx_data;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] rx_data;
    logic       ok;
    logic [3:0] rx_count;
    logic [2:0] line_mode;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [3:0] count;
  } fifo_stat_t;

endpackage

@@ src/hdu_fifo.sv @@
// ---------------------------------------------------------------------------
// hdu_fifo
// Byte ring FIFO with one spare slot and a registered head-of-queue read.
// ---------------------------------------------------------------------------
module hdu_fifo #(
  parameter int DEPTH = hdu_pkg::RX_DEPTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hdu_pkg::fifo_ctl_t ctl,
  input  logic [7:0]         wdata,
  output logic [7:0]         rdata,
  output hdu_pkg::fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (PW > 4) ? PW : 4;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    head_r;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] wr_inc, rd_inc, fill;
  logic [CW-1:0] fill_ext;

  assign wr_inc = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (ctl.clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_nxt = wr_inc;
      end
      if (ctl.pop) begin
        rd_ptr_nxt = rd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // The head register always mirrors the entry at the read pointer; a write
  // to that entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= wdata;
    end
    if (ctl.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wdata;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign fill = wr_ptr_r - rd_ptr_r + ((wr_ptr_r < rd_ptr_r) ? DEPTH_P : '0);
  assign fill_ext = CW'(fill);

  assign rdata      = head_r;
  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.full  = (wr_inc == rd_ptr_r);
  assign stat.count = fill_ext[3:0];

endmodule

@@ src/half_duplex_uart_with_fifos.sv @@
// ---------------------------------------------------------------------------
// half_duplex_uart_with_fifos: half-duplex 8N1 UART with receive/transmit FIFOs
// The result of an accepted request is registered. A request can be accepted
// in every clock cycle while the skid entry is free, each one a single registered step.
// Synchronous active-low reset returns the line to idle, empties both FIFOs
// and loads the timing registers with their defaults; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module half_duplex_uart_with_fifos #(
  parameter int RX_DEPTH = hdu_pkg::RX_DEPTH_DFLT,
  parameter int TX_DEPTH = hdu_pkg::TX_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hdu_pkg::in_item_t             in_data,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output hdu_pkg::out_item_t            out_data,
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hdu_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [hdu_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [hdu_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int TW = hdu_pkg::TIMER_W;

  // -------------------------------------------------------------------------
  // Configuration registers. The port never stalls; a write lands on the
  // access cycle. Addresses past the last register read as zero and ignore
  // writes.
  // -------------------------------------------------------------------------
  logic [TW-1:0]     bit_period_r, start_delay_r, turnaround_r;
  logic              cfg_wr;
  hdu_pkg::cfg_reg_t cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = hdu_pkg::cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= hdu_pkg::BIT_PERIOD_RST;
      start_delay_r <= hdu_pkg::START_DELAY_RST;
      turnaround_r  <= hdu_pkg::TURNAROUND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        hdu_pkg::REG_BIT_PERIOD:  bit_period_r  <= cfg_pwdata[TW-1:0];
        hdu_pkg::REG_START_DELAY: start_delay_r <= cfg_pwdata[TW-1:0];
        hdu_pkg::REG_TURNAROUND:  turnaround_r  <= cfg_pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      hdu_pkg::REG_BIT_PERIOD:  cfg_prdata = hdu_pkg::CFG_DW'(bit_period_r);
      hdu_pkg::REG_START_DELAY: cfg_prdata = hdu_pkg::CFG_DW'(start_delay_r);
      hdu_pkg::REG_TURNAROUND:  cfg_prdata = hdu_pkg::CFG_DW'(turnaround_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Result buffering: a result register plus one skid entry. A request is
  // taken whenever the skid entry is free, so a stalled result does not
  // hold up the next request.
  // -------------------------------------------------------------------------
  logic               in_fire, out_fire;
  logic               out_valid_r, skid_valid_r;
  hdu_pkg::out_item_t out_r, skid_r, res;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  // -------------------------------------------------------------------------
  // FIFOs. Each one keeps its head entry in a register, so the byte to pop
  // or to frame is ready at the start of the cycle.
  // -------------------------------------------------------------------------
  hdu_pkg::fifo_ctl_t  rx_ctl, tx_ctl;
  hdu_pkg::fifo_stat_t rx_stat, tx_stat;
  logic [7:0]          rx_wdata, rx_head, tx_head;

  hdu_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rx_ctl),
    .wdata (rx_wdata),
    .rdata (rx_head),
    .stat  (rx_stat)
  );

  hdu_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tx_ctl),
    .wdata (in_data.tx_data),
    .rdata (tx_head),
    .stat  (tx_stat)
  );

  // -------------------------------------------------------------------------
  // Line state machine. The tick counter is bumped before it is compared,
  // and a count that wraps to zero also ends the interval, so a timing
  // register of zero behaves like one.
  // -------------------------------------------------------------------------
  hdu_pkg::mode_t mode_r, mode_nxt;
  hdu_pkg::req_t  req;
  logic [TW-1:0]  tick_r, tick_nxt, tick_inc, rx_target;
  logic [3:0]     bit_r, bit_nxt, bit_inc;
  logic [9:0]     sh_r, sh_nxt, rx_shift;
  logic           line_prev_r, line_prev_nxt;
  logic           fall_det, frame_done;
  logic           ok_c;
  logic [7:0]     rxd_c;

  assign req       = hdu_pkg::req_t'(in_data.req_type);
  assign tick_inc  = tick_r + 1'b1;
  assign bit_inc   = bit_r + 1'b1;
  assign fall_det  = line_prev_r & ~in_data.rx_line;
  assign rx_target = (bit_r == '0) ? start_delay_r : bit_period_r;
  // Receive shift: new bit enters at bit 7, the top two bits stay clear.
  assign rx_shift  = {2'b00, in_data.rx_line, sh_r[7:1]};
  assign rx_wdata  = rx_shift[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hdu_pkg::MODE_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      sh_r        <= hdu_pkg::SHIFT_IDLE;
      line_prev_r <= 1'b1;
    end else begin
      mode_r      <= mode_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      sh_r        <= sh_nxt;
      line_prev_r <= line_prev_nxt;
    end
  end

  // Next state, FIFO controls and the per-request status.
  always_comb begin
    mode_nxt      = mode_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    sh_nxt        = sh_r;
    line_prev_nxt = line_prev_r;
    rx_ctl        = '0;
    tx_ctl        = '0;
    ok_c          = 1'b1;
    rxd_c         = '0;
    frame_done    = 1'b0;
    if (in_fire) begin
      unique case (req)
        hdu_pkg::REQ_TICK: begin
          line_prev_nxt = in_data.rx_line;
          unique case (mode_r)
            hdu_pkg::MODE_IDLE: begin
              if (fall_det) begin
                mode_nxt = hdu_pkg::MODE_RX;
                tick_nxt = '0;
                bit_nxt  = '0;
                sh_nxt   = hdu_pkg::SHIFT_RX_START;
              end
            end
            hdu_pkg::MODE_RX: begin
              tick_nxt = tick_inc;
              if (tick_inc >= rx_target || tick_inc == '0) begin
                sh_nxt   = rx_shift;
                tick_nxt = '0;
                bit_nxt  = bit_inc;
                if (bit_inc >= hdu_pkg::RX_DATA_BITS) begin
                  // A byte that meets a full FIFO is dropped.
                  rx_ctl.push = !rx_stat.full;
                  mode_nxt    = hdu_pkg::MODE_WAIT;
                  bit_nxt     = '0;
                  sh_nxt      = hdu_pkg::SHIFT_IDLE;
                end
              end
            end
            hdu_pkg::MODE_WAIT: begin
              if (fall_det) begin
                mode_nxt = hdu_pkg::MODE_RX;
                tick_nxt = '0;
                bit_nxt  = '0;
                sh_nxt   = hdu_pkg::SHIFT_RX_START;
              end else begin
                tick_nxt = tick_inc;
                if (tick_inc >= turnaround_r || tick_inc == '0) begin
                  tick_nxt = '0;
                  if (!tx_stat.empty) begin
                    mode_nxt = hdu_pkg::MODE_PRE;
                    bit_nxt  = '0;
                    sh_nxt   = hdu_pkg::SHIFT_IDLE;
                  end else begin
                    mode_nxt = hdu_pkg::MODE_IDLE;
                  end
                end
              end
            end
            hdu_pkg::MODE_PRE: begin
              tick_nxt = tick_inc;
              if (tick_inc >= bit_period_r || tick_inc == '0) begin
                frame_done = 1'b1;
              end
            end
            hdu_pkg::MODE_TX: begin
              tick_nxt = tick_inc;
              if (tick_inc >= bit_period_r || tick_inc == '0) begin
                tick_nxt = '0;
                bit_nxt  = bit_inc;
                if (bit_inc >= hdu_pkg::TX_FRAME_BITS) begin
                  frame_done = 1'b1;
                end else begin
                  sh_nxt = {1'b1, sh_r[9:1]};
                end
              end
            end
            default: ;
          endcase
        end
        hdu_pkg::REQ_PUSH: begin
          if (tx_stat.full) begin
            ok_c = 1'b0;
          end else begin
            tx_ctl.push = 1'b1;
            if (mode_r == hdu_pkg::MODE_IDLE) begin
              mode_nxt = hdu_pkg::MODE_PRE;
              tick_nxt = '0;
              bit_nxt  = '0;
              sh_nxt   = hdu_pkg::SHIFT_IDLE;
            end
          end
        end
        hdu_pkg::REQ_POP: begin
          if (rx_stat.empty) begin
            ok_c = 1'b0;
          end else begin
            rx_ctl.pop = 1'b1;
            rxd_c      = rx_head;
          end
        end
        hdu_pkg::REQ_CLEAR: begin
          rx_ctl.clear = 1'b1;
        end
        default: ;
      endcase
    end

    // End of the preamble or of a frame: frame the next queued byte with a
    // start and a stop bit, or fall back to idle when the queue is empty.
    if (frame_done) begin
      tick_nxt = '0;
      bit_nxt  = '0;
      if (!tx_stat.empty) begin
        tx_ctl.pop = 1'b1;
        sh_nxt     = {1'b1, tx_head, 1'b0};
        mode_nxt   = hdu_pkg::MODE_TX;
      end else begin
        sh_nxt   = hdu_pkg::SHIFT_IDLE;
        mode_nxt = hdu_pkg::MODE_IDLE;
      end
    end
  end

  // Result of the request, taken from the state as it stands after it.
  always_comb begin
    res.tx_line   = ((mode_nxt == hdu_pkg::MODE_TX) || (mode_nxt == hdu_pkg::MODE_PRE)) ?
                    sh_nxt[0] : 1'b1;
    res.rx_data   = rxd_c;
    res.ok        = ok_c;
    res.rx_count  = rx_ctl.clear ? 4'd0 :
                    rx_stat.count + 4'(rx_ctl.push) - 4'(rx_ctl.pop);
    res.line_mode = mode_nxt;
  end

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `HDU_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid entry without result")
  `HDU_NEVER(a_bit_range, bit_r >= hdu_pkg::TX_FRAME_BITS, "bit index past frame end")
  `HDU_ASSERT(a_idle_line_high, (mode_r == hdu_pkg::MODE_IDLE) || (mode_r == hdu_pkg::MODE_WAIT) |-> (sh_r == hdu_pkg::SHIFT_IDLE), "shifter not idle outside a frame")

endmodule

@@ dv/half_duplex_uart_with_fifos_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_uart_with_fifos_test
// Self-checking bench for the half-duplex UART. Requests (ticks with a serial
// line level, byte pushes, byte pops, receive clears) flow through a
// valid/ready driver while an in-bench line model predicts every status word.
// A monitor compares each returned status with the oldest prediction.
// ----------------------------------------------------------------------------
module half_duplex_uart_with_fifos_test;

  // Bench sizing. The FIFO depth matches the instance parameters below.
  localparam int FIFO_DEPTH = 16;
  localparam int DATA_BITS = 8;
  localparam int FRAME_BITS = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every block input starts at a known value.
  logic in_valid = 1'b0;
  logic in_ready;
  hdu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hdu_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [hdu_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [hdu_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [hdu_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  half_duplex_uart_with_fifos #(
    .RX_DEPTH(FIFO_DEPTH),
    .TX_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // 8 ns clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Requests waiting to be driven, and status words the line model expects.
  hdu_pkg::in_item_t host_requests[$];
  hdu_pkg::out_item_t predicted_status[$];

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  int err_count = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int settings_used = 0;
  int bytes_received = 0;
  int bytes_dropped = 0;
  int bytes_sent = 0;
  int pushes_refused = 0;
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // Line model: its own copy of the FIFOs, the line state machine and the
  // timing registers.
  // --------------------------------------------------------------------------
  logic [7:0] rx_mem[FIFO_DEPTH];
  logic [7:0] tx_mem[FIFO_DEPTH];
  int rx_rd, rx_wr, tx_rd, tx_wr;
  hdu_pkg::mode_t m_mode;
  logic [8:0] m_ticks;
  logic [3:0] m_bit;
  logic [9:0] m_shift;
  logic m_prev;
  logic [8:0] bit_period_r, start_delay_r, turnaround_r;

  function automatic void reset_line_model();
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      rx_mem[i] = 8'h00;
      tx_mem[i] = 8'h00;
    end
    rx_rd = 0;
    rx_wr = 0;
    tx_rd = 0;
    tx_wr = 0;
    m_mode = hdu_pkg::MODE_IDLE;
    m_ticks = '0;
    m_bit = '0;
    m_shift = 10'h3FF;
    m_prev = 1'b1;
    bit_period_r = 9'd104;
    start_delay_r = 9'd154;
    turnaround_r = 9'd256;
  endfunction

  function automatic int wrap_next(int p);
    return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int rx_level();
    return (rx_wr >= rx_rd) ? rx_wr - rx_rd : FIFO_DEPTH - rx_rd + rx_wr;
  endfunction

  function automatic void begin_reception();
    m_mode = hdu_pkg::MODE_RX;
    m_ticks = '0;
    m_bit = '0;
    m_shift = 10'h0FF;
  endfunction

  function automatic void begin_preamble();
    m_mode = hdu_pkg::MODE_PRE;
    m_ticks = '0;
    m_bit = '0;
    m_shift = 10'h3FF;
  endfunction

  // Frame the next queued byte as stop, data, start (LSB goes out first),
  // or fall back to idle when nothing is queued.
  function automatic void load_next_frame();
    if (tx_rd != tx_wr) begin
      m_shift = {1'b1, tx_mem[tx_rd], 1'b0};
      tx_rd = wrap_next(tx_rd);
      m_mode = hdu_pkg::MODE_TX;
      bytes_sent++;
    end else begin
      m_shift = 10'h3FF;
      m_mode = hdu_pkg::MODE_IDLE;
    end
    m_ticks = '0;
    m_bit = '0;
  endfunction

  // One timer tick. The counter is bumped before the compare, so a zero
  // timing register behaves like one, and a wrap to zero also fires.
  function automatic void line_tick(logic line);
    logic fall;
    logic [8:0] goal;
    int nxt;
    fall = m_prev && !line;
    m_prev = line;
    case (m_mode)
      hdu_pkg::MODE_IDLE: begin
        if (fall) begin_reception();
      end
      hdu_pkg::MODE_RX: begin
        goal = (m_bit == 0) ? start_delay_r : bit_period_r;
        m_ticks = m_ticks + 9'd1;
        if (m_ticks >= goal || m_ticks == 0) begin
          m_shift = {2'b00, line, m_shift[7:1]};
          m_ticks = '0;
          m_bit = m_bit + 4'd1;
          if (m_bit >= DATA_BITS) begin
            nxt = wrap_next(rx_wr);
            if (nxt != rx_rd) begin
              rx_mem[rx_wr] = m_shift[7:0];
              rx_wr = nxt;
              bytes_received++;
            end else begin
              bytes_dropped++;
            end
            m_mode = hdu_pkg::MODE_WAIT;
            m_bit = '0;
            m_shift = 10'h3FF;
          end
        end
      end
      hdu_pkg::MODE_WAIT: begin
        if (fall) begin
          begin_reception();
        end else begin
          m_ticks = m_ticks + 9'd1;
          if (m_ticks >= turnaround_r || m_ticks == 0) begin
            if (tx_rd != tx_wr) begin
              begin_preamble();
            end else begin
              m_mode = hdu_pkg::MODE_IDLE;
              m_ticks = '0;
            end
          end
        end
      end
      hdu_pkg::MODE_PRE: begin
        m_ticks = m_ticks + 9'd1;
        if (m_ticks >= bit_period_r || m_ticks == 0) load_next_frame();
      end
      default: begin
        m_ticks = m_ticks + 9'd1;
        if (m_ticks >= bit_period_r || m_ticks == 0) begin
          m_ticks = '0;
          m_bit = m_bit + 4'd1;
          if (m_bit >= FRAME_BITS) load_next_frame();
          else m_shift = {1'b1, m_shift[9:1]};
        end
      end
    endcase
  endfunction

  // Apply one accepted request to the model and return the status it yields.
  function automatic hdu_pkg::out_item_t uart_step(hdu_pkg::in_item_t req);
    hdu_pkg::out_item_t res;
    logic ok;
    logic [7:0] rxd;
    int nxt;
    ok = 1'b1;
    rxd = 8'h00;
    case (req.req_type)
      hdu_pkg::REQ_TICK: line_tick(req.rx_line);
      hdu_pkg::REQ_PUSH: begin
        nxt = wrap_next(tx_wr);
        if (nxt == tx_rd) begin
          ok = 1'b0;
          pushes_refused++;
        end else begin
          tx_mem[tx_wr] = req.tx_data;
          tx_wr = nxt;
          if (m_mode == hdu_pkg::MODE_IDLE) begin_preamble();
        end
      end
      hdu_pkg::REQ_POP: begin
        if (rx_rd == rx_wr) begin
          ok = 1'b0;
        end else begin
          rxd = rx_mem[rx_rd];
          rx_rd = wrap_next(rx_rd);
        end
      end
      default: begin
        rx_rd = 0;
        rx_wr = 0;
      end
    endcase
    res.tx_line = (m_mode == hdu_pkg::MODE_TX || m_mode == hdu_pkg::MODE_PRE) ?
                  m_shift[0] : 1'b1;
    res.rx_data = rxd;
    res.ok = ok;
    res.rx_count = 4'(rx_level());
    res.line_mode = m_mode;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A request is accepted at an edge where valid and ready are both
  // high; the model is stepped right there. A new request (or a gap) is
  // chosen only once the slot is free, so valid and the payload hold steady
  // while the block stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_status.push_back(uart_step(in_data));
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (host_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_data <= host_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each accepted status word is checked field by field against the
  // oldest prediction; ready is redrawn on every edge.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    hdu_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          note_mismatch("status with nothing outstanding, line_mode", out_data.line_mode, -1);
        end else begin
          want = predicted_status.pop_front();
          if (out_data.tx_line !== want.tx_line)
            note_mismatch("tx_line", out_data.tx_line, want.tx_line);
          if (out_data.rx_data !== want.rx_data)
            note_mismatch("rx_data", out_data.rx_data, want.rx_data);
          if (out_data.ok !== want.ok)
            note_mismatch("ok", out_data.ok, want.ok);
          if (out_data.rx_count !== want.rx_count)
            note_mismatch("rx_count", out_data.rx_count, want.rx_count);
          if (out_data.line_mode !== want.line_mode)
            note_mismatch("line_mode", out_data.line_mode, want.line_mode);
        end
        results_checked++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d status words outstanding",
               cycle_count, predicted_status.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration access: setup cycle, then access cycle until pready.
  // --------------------------------------------------------------------------
  task automatic write_timing_reg(hdu_pkg::cfg_reg_t idx, logic [8:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      hdu_pkg::REG_BIT_PERIOD: bit_period_r = value;
      hdu_pkg::REG_START_DELAY: start_delay_r = value;
      default: turnaround_r = value;
    endcase
  endtask

  // Block until every queued request went out and every status came back,
  // then let the registered result path settle.
  task automatic wait_drained();
    while (host_requests.size() != 0 || in_valid || predicted_status.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(int bp, int sd, int ta);
    wait_drained();
    write_timing_reg(hdu_pkg::REG_BIT_PERIOD, 9'(bp));
    write_timing_reg(hdu_pkg::REG_START_DELAY, 9'(sd));
    write_timing_reg(hdu_pkg::REG_TURNAROUND, 9'(ta));
    settings_used++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Request builders. Fields a request does not use get random values so the
  // block is seen to ignore them.
  // --------------------------------------------------------------------------
  task automatic add_req(hdu_pkg::req_t kind, logic line, logic [7:0] data);
    hdu_pkg::in_item_t item;
    item.req_type = kind;
    item.rx_line = line;
    item.tx_data = data;
    host_requests.push_back(item);
  endtask

  task automatic add_tick(logic line);
    add_req(hdu_pkg::REQ_TICK, line, 8'($urandom));
  endtask

  task automatic add_host(hdu_pkg::req_t kind, logic [7:0] data);
    add_req(kind, 1'($urandom), data);
  endtask

  task automatic add_ticks(int n, logic line);
    for (int i = 0; i < n; i++) add_tick(line);
  endtask

  task automatic add_random_host_op();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) add_host(hdu_pkg::REQ_PUSH, 8'($urandom));
    else if (pick < 9) add_host(hdu_pkg::REQ_POP, 8'($urandom));
    else add_host(hdu_pkg::REQ_CLEAR, 8'($urandom));
  endtask

  // Serial waveform of one 8N1 frame at the given bit period: a high tick to
  // arm the edge detector, then start, data LSB first and stop. A short
  // length cuts the frame off to make a broken one. With mixing on, host
  // requests land between ticks now and then.
  task automatic add_rx_frame(logic [7:0] b, int eff, int len, bit mix);
    int bitno;
    logic level;
    add_tick(1'b1);
    for (int k = 0; k < len; k++) begin
      if (mix && $urandom_range(0, 19) == 0) add_random_host_op();
      bitno = k / eff;
      if (bitno == 0) level = 1'b0;
      else if (bitno <= DATA_BITS) level = b[bitno-1];
      else level = 1'b1;
      add_tick(level);
    end
  endtask

  // Drain any pending transmission, then stream more frames than the receive
  // FIFO can hold without popping, so later bytes are dropped.
  task automatic fill_rx_fifo(int eff, int ta);
    add_ticks((FIFO_DEPTH * FRAME_BITS + 1) * eff + ta + 2, 1'b1);
    for (int i = 0; i < FIFO_DEPTH + 1; i++) begin
      add_rx_frame(8'($urandom), eff, FRAME_BITS * eff, 1'b0);
      add_ticks($urandom_range(0, 1), 1'b1);
    end
  endtask

  // Random traffic: mostly well-formed frames and idle-high stretches that
  // let bursts go out, mixed with host bursts, noise and broken frames.
  task automatic run_traffic(int n, int bp, int ta);
    int eff;
    int goal;
    int pick;
    eff = (bp < 1) ? 1 : bp;
    goal = host_requests.size() + n;
    while (host_requests.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        add_rx_frame(8'($urandom), eff, FRAME_BITS * eff, 1'b1);
        add_ticks($urandom_range(0, 2 * eff), 1'b1);
      end else if (pick < 50) begin
        add_ticks($urandom_range(1, (FRAME_BITS + 2) * eff + ta), 1'b1);
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 4)) add_host(hdu_pkg::REQ_PUSH, 8'($urandom));
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 4)) add_host(hdu_pkg::REQ_POP, 8'($urandom));
      end else if (pick < 71) begin
        add_host(hdu_pkg::REQ_CLEAR, 8'($urandom));
      end else if (pick < 76) begin
        repeat ($urandom_range(1, 8)) add_tick(1'($urandom));
      end else if (pick < 81) begin
        add_rx_frame(8'($urandom), eff, $urandom_range(1, FRAME_BITS * eff - 1), 1'b0);
        add_ticks($urandom_range(1, 3 * eff), 1'b1);
      end else if (pick < 85) begin
        // More pushes than the transmit FIFO can take.
        repeat (FIFO_DEPTH + 1) add_host(hdu_pkg::REQ_PUSH, 8'($urandom));
      end else begin
        repeat (FIFO_DEPTH) add_host(hdu_pkg::REQ_POP, 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    int bp;
    logic [7:0] pattern;
    reset_line_model();
    send_gap_pct = 20;
    recv_stall_pct = 51;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;
    @(negedge clk);

    // Reset timing: empty pop, clear, an edge that starts reception, and
    // pushes of both byte extremes while receiving (no preamble yet).
    add_host(hdu_pkg::REQ_POP, 8'hFF);
    add_host(hdu_pkg::REQ_CLEAR, 8'h00);
    add_tick(1'b1);
    add_tick(1'b0);
    add_host(hdu_pkg::REQ_PUSH, 8'h00);
    add_host(hdu_pkg::REQ_PUSH, 8'hFF);
    add_tick(1'b0);
    add_host(hdu_pkg::REQ_POP, 8'h00);

    // All timing registers at zero act like one tick: the frame in progress
    // samples on every tick, the wait ends at once and the burst starts.
    // Falling edges while transmitting must be ignored.
    start_phase(0, 0, 0);
    pattern = 8'hA5;
    for (int i = 0; i < DATA_BITS; i++) add_tick(pattern[i]);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_host(hdu_pkg::REQ_POP, 8'h5A);
    add_host(hdu_pkg::REQ_POP, 8'hA5);
    add_host(hdu_pkg::REQ_CLEAR, 8'hFF);

    // Sender idles more lightly than the receiver.
    start_phase(1, 1, 1);
    fill_rx_fifo(1, 1);
    run_traffic(65, 1, 1);
    start_phase(2, 3, 5);
    run_traffic(65, 2, 5);

    // Roles swapped; the widest timing only sees the start of a frame, with
    // a push and a pop while it waits for the first sample.
    send_gap_pct = 51;
    recv_stall_pct = 20;
    bp = $urandom_range(3, 6);
    start_phase(bp, bp + bp / 2, $urandom_range(1, 40));
    run_traffic(65, bp, turnaround_r);
    start_phase(256, 384, 256);
    add_tick(1'b1);
    add_tick(1'b0);
    add_ticks(20, 1'b0);
    add_host(hdu_pkg::REQ_PUSH, 8'($urandom));
    add_ticks(20, 1'b1);
    add_host(hdu_pkg::REQ_POP, 8'($urandom));

    // Back to back, no idling on either side.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    bp = $urandom_range(1, 4);
    start_phase(bp, $urandom_range(bp, 2 * bp), $urandom_range(1, 64));
    run_traffic(65, bp, turnaround_r);
    start_phase(1, 2, 1);
    run_traffic(65, 1, 1);

    wait_drained();
    $display("Checked %0d status words from %0d requests under %0d timing settings.",
             results_checked, requests_sent, settings_used);
    $display("Frames: %0d bytes stored, %0d dropped on a full FIFO, %0d sent, %0d pushes refused.",
             bytes_received, bytes_dropped, bytes_sent, pushes_refused);
    if (err_count == 0 && predicted_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
